// File: hw/rtl/ppr_pkg.sv
// ----------------------------------------------------------------------------
// ppr_pkg: shared types and codes for the palette pixel renderer
// Request payload structs, command, channel-select, format, source, register codes.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int PALETTE_ENTRIES_DEF = 32;

  localparam int PIXEL_W = 16;
  localparam int CLUT_W  = 8;
  localparam int COLOR_W = 24;
  localparam int FIELD_W = 5;

  typedef enum logic [0:0] {
    CMD_RENDER = 1'b0,
    CMD_WRITE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CHAN_ALL   = 2'd0,
    CHAN_BLUE  = 2'd1,
    CHAN_GREEN = 2'd2,
    CHAN_RED   = 2'd3
  } chan_sel_t;

  typedef enum logic [1:0] {
    FMT_XRGB8888 = 2'd0,
    FMT_RGB565   = 2'd1,
    FMT_RGB1555  = 2'd2,
    FMT_RSVD     = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    SRC_BACKGROUND = 2'd0,
    SRC_BYPASS     = 2'd1,
    SRC_PALETTE    = 2'd2,
    SRC_NONE       = 2'd3
  } src_t;

  typedef enum logic [1:0] {
    REG_OUTPUT_FORMAT    = 2'd0,
    REG_BYPASS_ENABLE    = 2'd1,
    REG_BACKGROUND_COLOR = 2'd2,
    REG_UNUSED           = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [0:0]         command;
    logic [PIXEL_W-1:0] pixel;
    logic [FIELD_W-1:0] clut_index;
    logic [CLUT_W-1:0]  red_value;
    logic [CLUT_W-1:0]  green_value;
    logic [CLUT_W-1:0]  blue_value;
    logic [1:0]         channel_select;
  } in_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color_out;
    logic [1:0]         color_source;
  } out_req_t;

  typedef struct packed {
    logic [1:0]         output_format;
    logic               bypass_enable;
    logic [COLOR_W-1:0] background_color;
  } cfg_regs_t;

endpackage

// File: hw/rtl/ppr_clut.sv
// ----------------------------------------------------------------------------
// ppr_clut: one color lookup table
// Synchronous memory with registered read; per-entry valid bits
// make unwritten entries read as zero right after reset.
// ----------------------------------------------------------------------------
module ppr_clut
  import ppr_pkg::*;
#(
  parameter int DEPTH  = PALETTE_ENTRIES_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [CLUT_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [CLUT_W-1:0] rd_data
);

  logic [CLUT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [CLUT_W-1:0] rd_q_r;
  logic              rd_vld_r;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // entry valid bits, cleared at once by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// File: hw/rtl/ppr_pack.sv
// ----------------------------------------------------------------------------
// ppr_pack: color source select and output packing
// Picks background, bypass or palette color and packs it per output format.
// ----------------------------------------------------------------------------
module ppr_pack
  import ppr_pkg::*;
(
  input  logic [PIXEL_W-1:0] pixel,
  input  logic [CLUT_W-1:0]  lut_red,
  input  logic [CLUT_W-1:0]  lut_green,
  input  logic [CLUT_W-1:0]  lut_blue,
  input  cfg_regs_t          cfg,
  output out_req_t           result
);

  logic [CLUT_W-1:0]  r_sel;
  logic [CLUT_W-1:0]  g_sel;
  logic [CLUT_W-1:0]  b_sel;
  logic [COLOR_W-1:0] packed_color;
  logic [COLOR_W-1:0] bypass_color;
  src_t               src;

  always_comb begin
    if (pixel == '0) begin
      src = SRC_BACKGROUND;
    end else if (cfg.bypass_enable && pixel[PIXEL_W-1]) begin
      src = SRC_BYPASS;
    end else begin
      src = SRC_PALETTE;
    end
  end

  always_comb begin
    if (src == SRC_BACKGROUND) begin
      r_sel = cfg.background_color[23:16];
      g_sel = cfg.background_color[15:8];
      b_sel = cfg.background_color[7:0];
    end else begin
      r_sel = lut_red;
      g_sel = lut_green;
      b_sel = lut_blue;
    end
  end

  always_comb begin
    case (fmt_t'(cfg.output_format))
      FMT_RGB565: begin
        packed_color = {8'd0, r_sel[7:3], g_sel[7:2], b_sel[7:3]};
        bypass_color = {9'd0, pixel[14:0]};
      end
      FMT_RGB1555: begin
        packed_color = {9'd0, r_sel[7:3], g_sel[7:3], b_sel[7:3]};
        bypass_color = {9'd0, pixel[14:0]};
      end
      default: begin
        packed_color = {r_sel, g_sel, b_sel};
        bypass_color = {pixel[14:10], 3'd0, pixel[9:5], 3'd0, pixel[4:0], 3'd0};
      end
    endcase
  end

  assign result.color_out    = (src == SRC_BYPASS) ? bypass_color : packed_color;
  assign result.color_source = src;

endmodule

// File: hw/rtl/palette_pixel_renderer_core.sv
// ----------------------------------------------------------------------------
// palette_pixel_renderer_core: palette color lookup stage
// Throughput: one request per cycle while out_stall lets results drain; the table
// read port is the sole serial step; renders pass stage 1 and the output register.
// Palette writes give no result and land in the tables at their accept edge.
// Reset (rst_n low, synchronous): config registers zero, tables read as zero
// from the first cycle after reset via per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module palette_pixel_renderer_core
  import ppr_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  // result output channel
  output logic        out_valid,
  input  logic        out_stall,
  output out_req_t    out_data,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [COLOR_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);

  // --------------------------------------------------------------------------
  // Configuration registers: always ready; not enforced, the user keeps them written only while the block idles
  // --------------------------------------------------------------------------
  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;
  logic      cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx_t'(cfg_index))
        REG_OUTPUT_FORMAT:    cfg_nxt.output_format    = cfg_data[1:0];
        REG_BYPASS_ENABLE:    cfg_nxt.bypass_enable    = cfg_data[0];
        REG_BACKGROUND_COLOR: cfg_nxt.background_color = cfg_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake
  //   stage 1 holds a render request while its table reads come back;
  //   the output register parts it from the downstream stall.
  // --------------------------------------------------------------------------
  logic            s1_valid_r, s1_valid_nxt;
  logic [PIXEL_W-1:0] s1_pixel_r;
  logic            out_valid_r, out_valid_nxt;
  out_req_t        out_data_r;
  logic            s1_move;
  logic            in_accept;
  logic            acc_render;
  logic            acc_write;
  out_req_t        s1_result;

  // advance stage 1 when the output register is empty or being drained
  assign s1_move    = s1_valid_r & (~out_valid_r | ~out_stall);
  // hold the input only when stage 1 is full and cannot advance
  assign in_stall   = s1_valid_r & ~s1_move;
  assign in_accept  = in_valid & ~in_stall;
  assign acc_render = in_accept & (cmd_t'(in_data.command) == CMD_RENDER);
  assign acc_write  = in_accept & (cmd_t'(in_data.command) == CMD_WRITE);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = acc_render;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: capture pixel with its table reads, load output on advance
  always_ff @(posedge clk) begin
    if (acc_render) begin
      s1_pixel_r <= in_data.pixel;
    end
    if (s1_move) begin
      out_data_r <= s1_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Color tables
  //   A write lands at its accept edge, so a render accepted on any later
  //   edge reads the new value; no forwarding path is needed.
  // --------------------------------------------------------------------------
  chan_sel_t         sel;
  logic              wr_red, wr_green, wr_blue;
  logic [CLUT_W-1:0] lut_red, lut_green, lut_blue;

  assign sel      = chan_sel_t'(in_data.channel_select);
  assign wr_red   = acc_write & ((sel == CHAN_ALL) | (sel == CHAN_RED));
  assign wr_green = acc_write & ((sel == CHAN_ALL) | (sel == CHAN_GREEN));
  assign wr_blue  = acc_write & ((sel == CHAN_ALL) | (sel == CHAN_BLUE));

  ppr_clut #(.DEPTH(PALETTE_ENTRIES)) u_clut_red (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_red),
    .wr_addr (in_data.clut_index[IDX_W-1:0]),
    .wr_data (in_data.red_value),
    .rd_en   (acc_render),
    .rd_addr (in_data.pixel[10 +: IDX_W]),
    .rd_data (lut_red)
  );

  ppr_clut #(.DEPTH(PALETTE_ENTRIES)) u_clut_green (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_green),
    .wr_addr (in_data.clut_index[IDX_W-1:0]),
    .wr_data (in_data.green_value),
    .rd_en   (acc_render),
    .rd_addr (in_data.pixel[5 +: IDX_W]),
    .rd_data (lut_green)
  );

  ppr_clut #(.DEPTH(PALETTE_ENTRIES)) u_clut_blue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_blue),
    .wr_addr (in_data.clut_index[IDX_W-1:0]),
    .wr_data (in_data.blue_value),
    .rd_en   (acc_render),
    .rd_addr (in_data.pixel[0 +: IDX_W]),
    .rd_data (lut_blue)
  );

  // --------------------------------------------------------------------------
  // Source select and packing on the stage 1 pixel
  // --------------------------------------------------------------------------
  ppr_pack u_pack (
    .pixel     (s1_pixel_r),
    .lut_red   (lut_red),
    .lut_green (lut_green),
    .lut_blue  (lut_blue),
    .cfg       (cfg_r),
    .result    (s1_result)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_render_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    acc_render |=> s1_valid_r)
    else $error("accepted render request did not reach stage 1");

  a_write_no_s1: assert property (@(posedge clk) disable iff (!rst_n)
    acc_write |=> !s1_valid_r)
    else $error("palette write produced a pending result");

  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r && out_data_r == $past(s1_result))
    else $error("stage 1 advance lost its result");

  a_drain_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !s1_move |=> !out_valid_r)
    else $error("delivered result repeated");

  a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r && $stable(s1_pixel_r))
    else $error("stage 1 request dropped under stall");

endmodule

// File: verif/palette_pixel_renderer_core_test.sv
// ----------------------------------------------------------------------------
// palette_pixel_renderer_core_test: self-checking bench for the palette stage
// Streams palette writes and pixel renders through the core while both sides
// idle and stall in random bursts. Expected colors are predicted as each
// request is accepted, and every result is compared field by field.
// ----------------------------------------------------------------------------
module palette_pixel_renderer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ppr_pkg::*;

  localparam int PHASES           = 12;
  localparam int PHASE_REQUESTS   = 170;
  localparam int LONG_HOLD_CYCLES = 300;
  // Allow extra settling after the last result before touching config.
  localparam int SETTLE_CYCLES    = 4;
  localparam int PRINT_CAP        = 100;

  // --------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_req_t            in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_req_t           out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [COLOR_W-1:0] cfg_data  = '0;

  palette_pixel_renderer_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Shadow copy of the palette tables and the configuration registers
  // --------------------------------------------------------------------------
  logic [CLUT_W-1:0]  red_lut   [PALETTE_ENTRIES_DEF];
  logic [CLUT_W-1:0]  green_lut [PALETTE_ENTRIES_DEF];
  logic [CLUT_W-1:0]  blue_lut  [PALETTE_ENTRIES_DEF];
  fmt_t               fmt_shadow;
  logic               bypass_shadow;
  logic [COLOR_W-1:0] bg_shadow;

  in_req_t  queued_requests [$];  // requests waiting for the driver
  out_req_t expected_colors [$];  // predicted results, oldest first

  bit offering;       // mirrors in_valid
  int send_gap;
  int stall_gap;
  bit idle_on;        // random idling on both sides
  bit long_hold;      // receiver hold-off, driven by its own process
  int mismatch_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the core wedges and results never arrive.
  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Mismatch reporting: one line per failure up to PRINT_CAP, counted always
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    // Keep the log short when the core is badly broken.
    if (mismatch_count < PRINT_CAP)
      $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  // Pack an 8-bit-per-channel color into the current output format. The
  // reserved format code packs like XRGB8888.
  function automatic logic [COLOR_W-1:0] pack_rgb(input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
    case (fmt_shadow)
      FMT_RGB565:  return {8'h00, r[7:3], g[7:2], b[7:3]};
      FMT_RGB1555: return {9'h000, r[7:3], g[7:3], b[7:3]};
      default:     return {r, g, b};
    endcase
  endfunction

  // Apply an accepted request: update the tables for a palette write, or
  // queue the expected color for a render.
  task automatic resolve_request(input in_req_t req);
    out_req_t    want;
    logic [15:0] px;
    logic [4:0]  idx;
    px  = req.pixel;
    idx = req.clut_index;
    if (req.command == CMD_WRITE) begin
      if (req.channel_select == CHAN_ALL || req.channel_select == CHAN_RED)
        red_lut[idx] = req.red_value;
      if (req.channel_select == CHAN_ALL || req.channel_select == CHAN_BLUE)
        blue_lut[idx] = req.blue_value;
      if (req.channel_select == CHAN_ALL || req.channel_select == CHAN_GREEN)
        green_lut[idx] = req.green_value;
      return;
    end
    if (px == '0) begin
      // Whole word zero: background, truncated into the output format.
      want.color_source = SRC_BACKGROUND;
      want.color_out    = pack_rgb(bg_shadow[23:16], bg_shadow[15:8], bg_shadow[7:0]);
    end else if (bypass_shadow && px[15]) begin
      want.color_source = SRC_BYPASS;
      if (fmt_shadow == FMT_RGB565 || fmt_shadow == FMT_RGB1555)
        want.color_out = {9'h000, px[14:0]};
      else
        want.color_out = {px[14:10], 3'b000, px[9:5], 3'b000, px[4:0], 3'b000};
    end else begin
      // Flag set without bypass still goes through the palette.
      want.color_source = SRC_PALETTE;
      want.color_out    = pack_rgb(red_lut[px[14:10]], green_lut[px[9:5]],
                                   blue_lut[px[4:0]]);
    end
    expected_colors.push_back(want);
  endtask

  task automatic check_color(input out_req_t got);
    out_req_t want;
    if (expected_colors.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: color %06h source %0d",
                                got.color_out, got.color_source));
      return;
    end
    want = expected_colors.pop_front();
    if (got.color_out !== want.color_out)
      report_mismatch($sformatf("color_out %06h, expected %06h",
                                got.color_out, want.color_out));
    if (got.color_source !== want.color_source)
      report_mismatch($sformatf("color_source %0d, expected %0d",
                                got.color_source, want.color_source));
  endtask

  // --------------------------------------------------------------------------
  // Request builders; unused fields carry random bits so every bit toggles
  // --------------------------------------------------------------------------
  function automatic in_req_t pixel_request(input logic [15:0] px);
    in_req_t req;
    req.command        = CMD_RENDER;
    req.pixel          = px;
    req.clut_index     = 5'($urandom);
    req.red_value      = 8'($urandom);
    req.green_value    = 8'($urandom);
    req.blue_value     = 8'($urandom);
    req.channel_select = 2'($urandom);
    return req;
  endfunction

  function automatic in_req_t write_request(input logic [4:0] idx,
                                            input logic [7:0] r,
                                            input logic [7:0] g,
                                            input logic [7:0] b,
                                            input chan_sel_t  sel);
    in_req_t req;
    req.command        = CMD_WRITE;
    req.pixel          = 16'($urandom);
    req.clut_index     = idx;
    req.red_value      = r;
    req.green_value    = g;
    req.blue_value     = b;
    req.channel_select = sel;
    return req;
  endfunction

  // Mostly renders, with a steady trickle of palette writes so lookups hit
  // freshly written entries; zero pixels get extra weight.
  function automatic in_req_t random_request();
    if ($urandom_range(0, 3) == 0)
      return write_request(5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           chan_sel_t'($urandom_range(0, 3)));
    if ($urandom_range(0, 9) == 0)
      return pixel_request(16'h0000);
    return pixel_request(16'($urandom_range(0, 16'hFFFF)));
  endfunction

  // --------------------------------------------------------------------------
  // Configuration writes and idle points
  // --------------------------------------------------------------------------
  task automatic write_register(input reg_idx_t idx, input logic [COLOR_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    // Hold the write until the core takes it.
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_OUTPUT_FORMAT:    fmt_shadow    = fmt_t'(value[1:0]);
      REG_BYPASS_ENABLE:    bypass_shadow = value[0];
      REG_BACKGROUND_COLOR: bg_shadow     = value;
      default: ;
    endcase
  endtask

  task automatic retune(input fmt_t f, input logic byp, input logic [COLOR_W-1:0] bg);
    write_register(REG_OUTPUT_FORMAT, COLOR_W'(f));
    write_register(REG_BYPASS_ENABLE, COLOR_W'(byp));
    write_register(REG_BACKGROUND_COLOR, bg);
  endtask

  // Wait until the sender is empty and every result is back, then give a
  // trailing palette write time to land before any config change.
  task automatic settle();
    do @(negedge clk);
    while (queued_requests.size() != 0 || offering || expected_colors.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: pop the next request, hold it until accepted, idle in bursts
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : request_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      send_gap = 0;
    end else begin
      if (offering && !in_stall) begin
        resolve_request(in_data);
        offering = 1'b0;
      end
      // Only pick a new request once the previous one is gone, so a
      // stalled payload never changes.
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (queued_requests.size() != 0) begin
          if (idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 16);
          end else begin
            in_data <= queued_requests.pop_front();
            offering = 1'b1;
          end
        end
      end
      in_valid <= offering;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check accepted results, stall in bursts or during the hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    bit stall_now;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_gap = 0;
    end else begin
      if (out_valid && !out_stall)
        check_color(out_data);
      stall_now = 1'b0;
      if (stall_gap > 0) begin
        stall_gap--;
        stall_now = 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_gap = $urandom_range(0, 16);
        stall_now = 1'b1;
      end
      out_stall <= stall_now || long_hold;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic byp;
    logic [COLOR_W-1:0] bg;
    foreach (red_lut[i]) begin
      red_lut[i]   = '0;
      green_lut[i] = '0;
      blue_lut[i]  = '0;
    end
    fmt_shadow     = FMT_XRGB8888;
    bypass_shadow  = 1'b0;
    bg_shadow      = '0;
    idle_on        = 1'b1;
    long_hold      = 1'b0;
    mismatch_count = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: background zero, empty tables, flag set without bypass.
    queued_requests.push_back(pixel_request(16'h0000));
    queued_requests.push_back(pixel_request(16'hFFFF));
    // Extremes of index and data, every channel select on one entry.
    queued_requests.push_back(write_request(5'd0, 8'hFF, 8'hFF, 8'hFF, CHAN_ALL));
    queued_requests.push_back(write_request(5'd31, 8'hAA, 8'h55, 8'hC3, CHAN_ALL));
    queued_requests.push_back(write_request(5'd31, 8'h12, 8'h00, 8'h00, CHAN_RED));
    queued_requests.push_back(write_request(5'd31, 8'h00, 8'h00, 8'h34, CHAN_BLUE));
    queued_requests.push_back(write_request(5'd31, 8'h00, 8'h56, 8'h00, CHAN_GREEN));
    queued_requests.push_back(write_request(5'd10, 8'h80, 8'h7F, 8'h01, CHAN_ALL));
    queued_requests.push_back(pixel_request(16'h7FFF));
    queued_requests.push_back(pixel_request(16'h8000));
    queued_requests.push_back(pixel_request(16'h294A));
    settle();

    // The unused register index must be harmless.
    write_register(REG_UNUSED, 24'hFFFFFF);

    // Bypass in each 16-bit format and in the reserved format.
    retune(FMT_RGB565, 1'b1, 24'hFFFFFF);
    queued_requests.push_back(pixel_request(16'h0000));
    queued_requests.push_back(pixel_request(16'hFFFF));
    queued_requests.push_back(pixel_request(16'h8000));
    queued_requests.push_back(pixel_request(16'h7FFF));
    settle();

    retune(FMT_RGB1555, 1'b1, 24'h123456);
    queued_requests.push_back(pixel_request(16'h0000));
    queued_requests.push_back(pixel_request(16'hFFFF));
    queued_requests.push_back(pixel_request(16'h7FFF));
    queued_requests.push_back(pixel_request(16'h8421));
    settle();

    retune(FMT_RSVD, 1'b1, 24'hA5C35A);
    queued_requests.push_back(pixel_request(16'h0000));
    queued_requests.push_back(pixel_request(16'hFFFF));
    queued_requests.push_back(pixel_request(16'h0421));
    queued_requests.push_back(pixel_request(16'h7FFF));
    settle();

    // Random phases: the first eight walk every format with bypass off and
    // on, the rest pick bypass at random.
    for (int p = 0; p < PHASES; p++) begin
      byp = (p < 8) ? 1'((p / 4) % 2) : 1'($urandom_range(0, 1));
      if (p == 0)
        bg = 24'hFFFFFF;
      else if (p == 1)
        bg = 24'h000000;
      else
        bg = COLOR_W'($urandom_range(0, 24'hFFFFFF));
      retune(fmt_t'(p % 4), byp, bg);

      // Run one phase clean, and keep the closing phase free of idling.
      idle_on = !(p == 9 || p == PHASES - 1);

      if (p == 5) begin
        // Hold off the receiver long enough to back the core up into its
        // input while the driver keeps offering requests.
        fork
          begin
            @(posedge clk);
            long_hold <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clk);
            long_hold <= 1'b0;
          end
        join_none
      end

      repeat (PHASE_REQUESTS) queued_requests.push_back(random_request());
      // Pause the sender until every result of this phase is back.
      settle();
    end

    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_colors.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
